// ===== rtl/core/gmde_pkg.sv =====
// ----------------------------------------------------------------------------
// gmde_pkg
// Shared constants and types for the occupancy-grid 3x3 dilate/erode block.
// ----------------------------------------------------------------------------
package gmde_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // Field and counter widths
    localparam int CELL_W    = 8;
    localparam int DIM_W     = 10;                       // map_height / map_width
    localparam int COL_W     = $clog2(MAX_WIDTH);        // line store address
    localparam int EMIT_W    = 19;                       // emitted cell count
    localparam int BASE_W    = 19;                       // row * width
    localparam int POS_W     = BASE_W + 1;
    localparam int DIV_CNT_W = $clog2(EMIT_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b1;

    // Cell codes
    localparam logic [CELL_W-1:0] CELL_UNMAPPED = 8'd0;
    localparam logic [CELL_W-1:0] CELL_MAPPED   = 8'd1;
    localparam logic [CELL_W-1:0] CELL_WALL     = 8'd2;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // One line store word: the two previous rows at one column
    typedef struct packed {
        logic [CELL_W-1:0] upper;
        logic [CELL_W-1:0] middle;
    } t_line_word;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,   // zero the line stores after reset
        ST_LOAD,    // start derived-counter recompute
        ST_DIV,     // bit-serial divide of emitted count by width
        ST_RUN      // stream cells
    } t_state;

endpackage

// ===== rtl/core/grid_map_dilate_erode.sv =====
// ----------------------------------------------------------------------------
// grid_map_dilate_erode
// 3x3 wall dilation and unmapped erosion over a raster occupancy-grid stream.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle while running and the output queue has room;
//   the line store read-modify-write takes one memory read and one write per
//   beat, with forwarding between neighbors. Results pass stage 1, the window
//   and stage 2 into the output queue and trail input by map_width+1 beats.
// Reset: a clear pass zeros the line stores, then a load and a divide rebuild
//   the frame counters; every config write also stalls input for the rebuild.
module grid_map_dilate_erode
    import gmde_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] cell_in
    input  logic                 s_axis_tuser,   // [0] action (1 = flush)
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] cell_out
    output logic                 m_axis_tlast    // frame_last
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [DIM_W-1:0]     r_h, r_w;
    logic [DIM_W-1:0]     cfg_h_sat, cfg_w_sat;

    logic [COL_W-1:0]     r_clr_addr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [DIM_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [BASE_W-1:0]    r_row_base;
    logic [EMIT_W-1:0]    r_emitted;
    logic [EMIT_W-1:0]    r_erow;
    logic [COL_W-1:0]     r_ecol;
    logic [EMIT_W-1:0]    r_total;

    logic                 in_acc;
    logic [CELL_W-1:0]    in_cell;
    logic [POS_W-1:0]     pos;
    logic                 emit, interior, last;
    logic                 col_wrap;

    logic [DIM_W-1:0]     rem_sh;
    logic                 div_ge;

    logic                 r_s1_valid, r_s1_emit, r_s1_interior, r_s1_last, r_s1_fwd;
    logic [COL_W-1:0]     r_s1_col;
    logic [CELL_W-1:0]    r_s1_cell;
    t_line_word           r_s1_fwd_word;
    t_line_word           ls_rdata, s1_rd_word, s1_wr_word;

    logic                 ls_we;
    logic [COL_W-1:0]     ls_waddr;
    t_line_word           ls_wdata;

    logic [CELL_W-1:0]    r_win [9];
    logic                 r_s2_valid, r_s2_interior, r_s2_last;
    logic                 any_wall, any_mapped;
    logic [CELL_W-1:0]    s2_res;

    logic [CELL_W-1:0]    r_fifo_cell [FIFO_DEPTH];
    logic                 r_fifo_last [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_cnt, occ;
    logic                 push, pop;

    // ------------------------------------------------------------------
    // Config registers, saturated to 1..max on write
    // ------------------------------------------------------------------
    always_comb begin
        cfg_h_sat = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_h_sat = DIM_W'(1);
        end else if (i_cfg_wdata > DIM_W'(MAX_HEIGHT)) begin
            cfg_h_sat = DIM_W'(MAX_HEIGHT);
        end
        cfg_w_sat = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_w_sat = DIM_W'(1);
        end else if (i_cfg_wdata > DIM_W'(MAX_WIDTH)) begin
            cfg_w_sat = DIM_W'(MAX_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= DIM_W'(MAX_HEIGHT);
            r_w <= DIM_W'(MAX_WIDTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_HEIGHT: r_h <= cfg_h_sat;
                CFG_MAP_WIDTH:  r_w <= cfg_w_sat;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: clear, recompute, run
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(EMIT_W - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: ;
            default: n_state = ST_CLEAR;
        endcase
        // A config write outside the clear pass restarts the recompute
        if (i_cfg_we && r_state != ST_CLEAR) begin
            n_state = ST_LOAD;
        end
    end

    // Clear address and divide step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_div_cnt  <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
            end
            if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end else begin
                r_div_cnt <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: position tracking and output classification
    // ------------------------------------------------------------------
    assign occ = r_fifo_cnt + FIFO_CNT_W'(r_s1_valid & r_s1_emit)
                            + FIFO_CNT_W'(r_s2_valid);
    assign s_axis_tready = (r_state == ST_RUN) && (occ < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_cell = s_axis_tuser ? CELL_UNMAPPED : s_axis_tdata;

    assign pos      = POS_W'(r_row_base) + POS_W'(r_col);
    assign emit     = pos >= (POS_W'(r_w) + POS_W'(1));
    assign col_wrap = ({1'b0, r_col} + DIM_W'(1)) >= r_w;
    assign interior = (r_erow != '0)
                   && ((POS_W'(r_erow) + POS_W'(1)) < POS_W'(r_h))
                   && (r_ecol != '0)
                   && (({1'b0, r_ecol} + DIM_W'(1)) < r_w);
    assign last     = (POS_W'(r_emitted) + POS_W'(1)) >= POS_W'(r_total);

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign rem_sh = {r_ecol, r_erow[EMIT_W-1]};
    assign div_ge = rem_sh >= r_w;

    // Frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_row_base <= '0;
            r_emitted  <= '0;
            r_erow     <= '0;
            r_ecol     <= '0;
            r_total    <= EMIT_W'(MAX_WIDTH * MAX_HEIGHT);
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_total <= EMIT_W'(r_h * r_w);
                    r_erow  <= r_emitted;
                    r_ecol  <= '0;
                end
                ST_DIV: begin
                    r_row_base <= BASE_W'(r_row * r_w);
                    r_erow     <= {r_erow[EMIT_W-2:0], div_ge};
                    r_ecol     <= div_ge ? COL_W'(rem_sh - r_w) : COL_W'(rem_sh);
                end
                ST_RUN: begin
                    if (in_acc) begin
                        if (emit && last) begin
                            // End of frame: restart all position counters
                            r_row      <= '0;
                            r_col      <= '0;
                            r_row_base <= '0;
                            r_emitted  <= '0;
                            r_erow     <= '0;
                            r_ecol     <= '0;
                        end else begin
                            // Advance input position
                            if (col_wrap) begin
                                r_col <= '0;
                                r_row <= r_row + DIM_W'(1);
                                r_row_base <= (r_row == '1) ? '0
                                            : BASE_W'(r_row_base + BASE_W'(r_w));
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                            // Advance output position
                            if (emit) begin
                                r_emitted <= r_emitted + EMIT_W'(1);
                                if (({1'b0, r_ecol} + DIM_W'(1)) == r_w) begin
                                    r_ecol <= '0;
                                    r_erow <= r_erow + EMIT_W'(1);
                                end else begin
                                    r_ecol <= r_ecol + COL_W'(1);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read-modify-write
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            // Forward when the previous beat writes the entry read now
            r_s1_fwd   <= in_acc && r_s1_valid && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col      <= r_col;
        r_s1_cell     <= in_cell;
        r_s1_emit     <= emit;
        r_s1_interior <= interior;
        r_s1_last     <= last;
        r_s1_fwd_word <= s1_wr_word;
    end

    assign s1_rd_word        = r_s1_fwd ? r_s1_fwd_word : ls_rdata;
    assign s1_wr_word.upper  = s1_rd_word.middle;
    assign s1_wr_word.middle = r_s1_cell;

    // Write port: zeros during the clear pass, else the shifted column
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ls_we    = 1'b1;
            ls_waddr = r_clr_addr;
            ls_wdata = '0;
        end else begin
            ls_we    = r_s1_valid;
            ls_waddr = r_s1_col;
            ls_wdata = s1_wr_word;
        end
    end

    gmde_line_store u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (ls_wdata),
        .i_raddr (r_col),
        .o_rdata (ls_rdata)
    );

    // Shift the 3x3 window left and load the new right column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3 + 0] <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= s1_rd_word.upper;
            r_win[5] <= s1_rd_word.middle;
            r_win[8] <= r_s1_cell;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: neighbor rule on the centered window
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_interior <= r_s1_interior;
        r_s2_last     <= r_s1_last;
    end

    always_comb begin
        any_wall   = 1'b0;
        any_mapped = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                any_wall   = any_wall   | (r_win[k] == CELL_WALL);
                any_mapped = any_mapped | (r_win[k] == CELL_MAPPED);
            end
        end
        s2_res = r_win[4];
        if (r_s2_interior) begin
            if (r_win[4] != CELL_WALL && any_wall) begin
                s2_res = CELL_WALL;
            end else if (r_win[4] == CELL_UNMAPPED && any_mapped) begin
                s2_res = CELL_MAPPED;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    assign push = r_s2_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_cell[r_wr_ptr] <= s2_res;
            r_fifo_last[r_wr_ptr] <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = r_fifo_cell[r_rd_ptr];
    assign m_axis_tlast  = r_fifo_last[r_rd_ptr];

endmodule

// ===== rtl/core/gmde_line_store.sv =====
// ----------------------------------------------------------------------------
// gmde_line_store
// Two-row line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmde_line_store
    import gmde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_waddr,
    input  t_line_word       i_wdata,
    input  logic [COL_W-1:0] i_raddr,
    output t_line_word       o_rdata
);

    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the occupancy-grid 3x3 dilate/erode stream block.
// A built-in predictor runs the same line stores and window as the block.
// Every beat that is accepted is fed through it. Each output beat is
// compared with the oldest predicted cell. Directed frames, frame-size
// extremes, mid-frame resizing, a long output stall and random frames run
// under changing valid/ready gaps.
// ----------------------------------------------------------------------------
module testbench;
    import gmde_pkg::*;

    localparam bit ACT_CELL  = 1'b0;
    localparam bit ACT_FLUSH = 1'b1;

    localparam int RX_STALL_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct {
        logic [CELL_W-1:0] code;
        logic              last;
    } grid_cell_t;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MAP_HEIGHT;
    logic [DIM_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [7:0] cell_in
    logic                 s_axis_tuser = 1'b0;  // [0] action (1 = flush)
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [7:0] cell_out
    logic                 m_axis_tlast;         // frame_last

    // Predictor state
    logic [DIM_W-1:0]  rows_reg = 10'd512;
    logic [DIM_W-1:0]  cols_reg = 10'd512;
    logic [CELL_W-1:0] upper_line [MAX_WIDTH];
    logic [CELL_W-1:0] middle_line [MAX_WIDTH];
    logic [CELL_W-1:0] window [9];
    int unsigned       row_at;
    int unsigned       col_at;
    int unsigned       emitted;

    grid_cell_t pending_cells [$];

    // Run bookkeeping
    int error_count    = 0;
    int beats_sent     = 0;
    int cells_checked  = 0;
    int frames_seen    = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int stall_requests = 0;

    grid_map_dilate_erode u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int k = 0; k < 9; k++) window[k] = '0;
        row_at  = 0;
        col_at  = 0;
        emitted = 0;
    endfunction

    // Advance the raster by one beat; queue the cell it completes, if any
    function automatic void dilate_step(bit flush, logic [CELL_W-1:0] raw);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        int unsigned       pos;
        int unsigned       erow;
        int unsigned       ecol;
        logic [CELL_W-1:0] cell_v;
        logic [CELL_W-1:0] centre;
        logic [CELL_W-1:0] res;
        bit                near_wall;
        bit                near_mapped;
        bit                is_last;
        grid_cell_t        item;
        w      = usable_dim(cols_reg, MAX_WIDTH);
        h      = usable_dim(rows_reg, MAX_HEIGHT);
        col    = col_at % MAX_WIDTH;
        cell_v = flush ? CELL_UNMAPPED : raw;
        pos    = row_at * w + col_at;

        // Slide the window left and load the new right column
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2]        = upper_line[col];
        window[5]        = middle_line[col];
        window[8]        = cell_v;
        upper_line[col]  = middle_line[col];
        middle_line[col] = cell_v;

        if (col_at + 1 >= w) begin
            col_at = 0;
            row_at = (row_at + 1) & 32'h3FF;
        end else begin
            col_at = col_at + 1;
        end

        if (pos < w + 1) return;

        erow    = emitted / w;
        ecol    = emitted % w;
        centre  = window[4];
        res     = centre;
        near_wall   = 1'b0;
        near_mapped = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                if (window[k] == CELL_WALL) near_wall = 1'b1;
                if (window[k] == CELL_MAPPED) near_mapped = 1'b1;
            end
        end
        // Interior cells only: wall dilation wins over unmapped erosion
        if (erow >= 1 && erow + 1 < h && ecol >= 1 && ecol + 1 < w) begin
            if (centre != CELL_WALL && near_wall) res = CELL_WALL;
            else if (centre == CELL_UNMAPPED && near_mapped) res = CELL_MAPPED;
        end
        is_last   = (emitted + 1 >= h * w);
        item.code = res;
        item.last = is_last;
        pending_cells.push_back(item);
        if (is_last) begin
            emitted = 0;
            row_at  = 0;
            col_at  = 0;
        end else begin
            emitted = (emitted + 1) & 32'h7FFFF;
        end
    endfunction

    function automatic logic [CELL_W-1:0] rand_cell();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return CELL_UNMAPPED;
        if (pick < 65) return CELL_MAPPED;
        if (pick < 85) return CELL_WALL;
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one beat, with random gaps ahead of it; valid stays up on return
    task automatic push_cell(bit action, logic [CELL_W-1:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        dilate_step(action, data);
        beats_sent++;
    endtask

    // Random cells, some turned into flushes, then a run of flush beats
    task automatic send_frame(int unsigned n_cells, int unsigned n_flush, int flush_pct);
        for (int unsigned i = 0; i < n_cells; i++) begin
            if ($urandom_range(0, 99) < flush_pct) push_cell(ACT_FLUSH, $urandom_range(0, 255));
            else push_cell(ACT_CELL, rand_cell());
        end
        for (int unsigned i = 0; i < n_flush; i++) push_cell(ACT_FLUSH, $urandom_range(0, 255));
    endtask

    // Drop valid and hold until every predicted cell has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAP_HEIGHT) rows_reg = value;
        else cols_reg = value;
    endtask

    // Flush until the raster sits at the start of a frame
    task automatic finish_frame();
        while (!(row_at == 0 && col_at == 0 && emitted == 0)) push_cell(ACT_FLUSH, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    // Random ready, with a long hold-off whenever one is requested
    int stall_seen = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_seen != stall_requests) begin
            stall_seen = stall_requests;
            stall_left = RX_STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare each output beat against the oldest predicted cell
    always @(posedge i_clk) begin
        grid_cell_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cells.size() == 0) begin
                error_count++;
                $display("%0t: output beat with none expected, got code %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_cells.pop_front();
                cells_checked++;
                if (m_axis_tlast === 1'b1) frames_seen++;
                if (m_axis_tdata !== want.code) begin
                    error_count++;
                    $display("%0t: cell_out mismatch, expected %0d got %0d",
                             $time, want.code, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    error_count++;
                    $display("%0t: frame_last mismatch, expected %0b got %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // End the run when neither side moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Hand-built 4x5 map: erosion to mapped, dilation of unmapped
    // cells, kept wall, kept foreign code, borders, and a flush mid-frame
    task automatic test_directed();
        logic [CELL_W-1:0] grid [20];
        grid = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd1,
                 8'd0, 8'd0, 8'd0,   8'd0, 8'd2,
                 8'd0, 8'd200, 8'd0, 8'd2, 8'd128,
                 8'd1, 8'd1, 8'd0,   8'd0, 8'd0};
        write_reg(CFG_MAP_HEIGHT, 10'd4);
        write_reg(CFG_MAP_WIDTH, 10'd5);
        for (int i = 0; i < 20; i++) begin
            if (i == 17) push_cell(ACT_FLUSH, 8'hFF);
            else push_cell(ACT_CELL, grid[i]);
        end
        for (int i = 0; i < 6; i++) push_cell(ACT_FLUSH, 8'h00);
    endtask

    // Shrink height below the emitted count, then width below the column
    task automatic test_midframe_resize();
        finish_frame();
        write_reg(CFG_MAP_HEIGHT, 10'd8);
        write_reg(CFG_MAP_WIDTH, 10'd8);
        send_frame(30, 0, 0);
        write_reg(CFG_MAP_HEIGHT, 10'd2);
        send_frame(6, 0, 0);
        write_reg(CFG_MAP_WIDTH, 10'd3);
        finish_frame();
    endtask

    // Zero and saturated register values, single row and single column
    task automatic test_extremes();
        finish_frame();
        write_reg(CFG_MAP_HEIGHT, 10'd0);
        write_reg(CFG_MAP_WIDTH, 10'd0);
        send_frame(1, 2, 0);
        write_reg(CFG_MAP_HEIGHT, 10'd1023);
        write_reg(CFG_MAP_WIDTH, 10'd1);
        send_frame(512, 2, 0);
        write_reg(CFG_MAP_HEIGHT, 10'd1);
        write_reg(CFG_MAP_WIDTH, 10'd5);
        send_frame(5, 6, 0);
        write_reg(CFG_MAP_HEIGHT, 10'd3);
        write_reg(CFG_MAP_WIDTH, 10'd1023);
        send_frame(3 * MAX_WIDTH, MAX_WIDTH + 1, 2);
    endtask

    // Hold the output off while the input keeps offering a whole frame
    task automatic test_output_stall();
        finish_frame();
        write_reg(CFG_MAP_HEIGHT, 10'd5);
        write_reg(CFG_MAP_WIDTH, 10'd6);
        stall_requests++;
        send_frame(30, 7, 0);
        wait_drained();
    endtask

    // Mostly whole frames of random size and content, some broken ones
    task automatic test_random_frames(int budget);
        int          start;
        int unsigned w;
        int unsigned h;
        int unsigned kind;
        start = beats_sent;
        while (beats_sent - start < budget) begin
            finish_frame();
            if ($urandom_range(0, 99) < 40) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                h = $urandom_range(1, 8);
                if ($urandom_range(0, 19) == 0) w = 0;
                if ($urandom_range(0, 19) == 0) h = 0;
                write_reg(CFG_MAP_WIDTH, w);
                write_reg(CFG_MAP_HEIGHT, h);
            end
            w    = usable_dim(cols_reg, MAX_WIDTH);
            h    = usable_dim(rows_reg, MAX_HEIGHT);
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                send_frame(h * w, w + 1, 10);
            end else if (kind < 15) begin
                // Cut the frame short; the next pass flushes it out
                send_frame($urandom_range(0, h * w - 1), w + 1, 0);
            end else if (kind < 20) begin
                // Spill cells past the frame into the next one
                send_frame(h * w, w + 1, 0);
                send_frame($urandom_range(1, 2 * w), 0, 0);
            end else begin
                send_frame(h * w, w + 1, 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 9;
        sink_idle_pct = 62;
        test_directed();
        test_midframe_resize();
        test_random_frames(220);

        src_idle_pct  = 62;
        sink_idle_pct = 9;
        test_extremes();
        test_random_frames(220);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_output_stall();
        test_random_frames(220);

        wait_drained();
        $display("summary: %0d input beats, %0d cells checked, %0d frames closed",
                 beats_sent, cells_checked, frames_seen);
        $display("summary: directed map, resize mid-frame, size extremes, long stall, %0s",
                 "random frames");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
